@@ hw/rtl/pmdsa_pkg.sv @@
// Shared types and constants for the periodic minimum-distance site acceptor.
// Holds the item structs, the status and sequencer codes and the axis distance function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmdsa_pkg;

    // Fixed field widths.
    localparam int COORD_W  = 16;
    localparam int DIST_W   = 34;
    localparam int TGT_W    = 11;
    localparam int IDX_W    = 10;
    localparam int HELD_W   = 11;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST_SQ  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [COORD_W-1:0] BOX_RESET    = 16'hFFFF;
    localparam logic [DIST_W-1:0]  MIN_D2_RESET = '0;
    localparam logic [TGT_W-1:0]   TARGET_RESET = 11'd1024;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_REJECT = 2'd0,
        STAT_ACCEPT = 2'd1,
        STAT_RANGE  = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_RESULT
    } seq_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] cand_x;
        logic [COORD_W-1:0] cand_y;
    } cand_item_t;

    typedef struct packed {
        status_t             status;
        logic [IDX_W-1:0]    site_index;
        logic [HELD_W-1:0]   sites_held;
        logic                done_res;
    } result_item_t;

    // Periodic minimum-image distance along one axis. When the box shrank after
    // a site was stored, the wrapped difference is taken as an absolute value.
    function automatic logic [COORD_W-1:0] axis_dist(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b,
        input logic [COORD_W-1:0] len
    );
        logic [COORD_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        if ({d, 1'b0} > {1'b0, len}) begin
            d = (len >= d) ? (len - d) : (d - len);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/periodic_min_distance_site_acceptor.sv @@
// Periodic minimum-distance site acceptor: dart throwing on a periodic box.
// One item at a time: the single site memory read port is swept once over the stored sites for
// each item, and the site is written when no stored site is too close; full and out-of-range
// items skip the sweep. Output stalls hold an item until its result can be loaded.
// Reset clears the count and the sequencer and restores the configuration defaults; site memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module periodic_min_distance_site_acceptor
    import pmdsa_pkg::*;
#(
    parameter int MAX_SITES = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Candidate channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire cand_item_t             in_item,
    // Result channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output result_item_t                out_item,
    // Configuration write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [DIST_W-1:0]      cfg_data
);

    localparam int ADDR_W = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int CNT_W  = $clog2(MAX_SITES + 1);
    localparam int LIM_W  = (CNT_W > TGT_W) ? CNT_W : TGT_W;
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_SITES);

    // Configuration registers.
    logic [COORD_W-1:0] box_width_reg;
    logic [COORD_W-1:0] box_height_reg;
    logic [DIST_W-1:0]  min_dist_sq_reg;
    logic [TGT_W-1:0]   target_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_width_reg    <= BOX_RESET;
            box_height_reg   <= BOX_RESET;
            min_dist_sq_reg  <= MIN_D2_RESET;
            target_count_reg <= TARGET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BOX_WIDTH:    box_width_reg    <= cfg_data[COORD_W-1:0];
                CFG_BOX_HEIGHT:   box_height_reg   <= cfg_data[COORD_W-1:0];
                CFG_MIN_DIST_SQ:  min_dist_sq_reg  <= cfg_data;
                CFG_TARGET_COUNT: target_count_reg <= cfg_data[TGT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Acceptance limit is the smaller of the target count and the memory depth.
    logic [LIM_W-1:0] tgt_ext;
    logic [LIM_W-1:0] limit;
    logic [LIM_W-1:0] count_ext;
    logic             is_full;

    // Sequencer and scan state.
    seq_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    rd_idx_reg;
    logic                reject_reg;
    status_t             status_reg;
    logic [IDX_W-1:0]    site_index_reg;
    cand_item_t          cand_reg;

    // Read pipeline: memory data, axis distances, squares.
    logic                v1_reg, v2_reg, v3_reg;
    logic [COORD_W-1:0]  rdx_reg, rdy_reg;
    logic [COORD_W-1:0]  dx_reg, dy_reg;
    logic [2*COORD_W-1:0] sqx_reg, sqy_reg;
    logic [2*COORD_W:0]  d2;
    logic                too_close;

    // Output register.
    logic                out_valid_reg;
    result_item_t        out_item_reg;

    // Controls from the output decoder.
    logic accept_in;
    logic issue;
    logic mem_we;
    logic load_out;
    logic scan_end;
    logic out_free;
    logic early_full;
    logic early_range;

    // Site memories.
    logic [COORD_W-1:0] site_x_mem [MAX_SITES];
    logic [COORD_W-1:0] site_y_mem [MAX_SITES];

    assign tgt_ext   = LIM_W'(target_count_reg);
    assign limit     = (tgt_ext > MAX_LIM) ? MAX_LIM : tgt_ext;
    assign count_ext = LIM_W'(count_reg);
    assign is_full   = (count_ext >= limit);

    assign early_full  = is_full;
    assign early_range = (in_item.cand_x == '0) || (in_item.cand_x >= box_width_reg) ||
                         (in_item.cand_y == '0) || (in_item.cand_y >= box_height_reg);

    assign scan_end = (rd_idx_reg == count_reg) && !v1_reg && !v2_reg && !v3_reg;
    assign out_free = !out_valid_reg || !out_stall;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (early_full || early_range) ? S_RESULT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = reject_reg ? S_RESULT : S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output decoding of the sequencer.
    always_comb
    begin
        in_stall = 1'b1;
        issue    = 1'b0;
        mem_we   = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            S_IDLE:   in_stall = 1'b0;
            S_SCAN:   issue    = (rd_idx_reg != count_reg);
            S_WRITE:  mem_we   = 1'b1;
            S_RESULT: load_out = out_free;
            default:  in_stall = 1'b1;
        endcase
    end

    assign accept_in = in_valid && !in_stall;

    // Sequencer registers, count and scan index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            reject_reg <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            if (accept_in)
            begin
                rd_idx_reg <= '0;
                reject_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (too_close)
                begin
                    reject_reg <= 1'b1;
                end
            end
            if (mem_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Item payload and result fields.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            cand_reg       <= in_item;
            site_index_reg <= '0;
            if (early_full)
            begin
                status_reg <= STAT_FULL;
            end
            else if (early_range)
            begin
                status_reg <= STAT_RANGE;
            end
            else
            begin
                status_reg <= STAT_REJECT;
            end
        end
        else if (mem_we)
        begin
            status_reg     <= STAT_ACCEPT;
            site_index_reg <= IDX_W'(count_reg);
        end
    end

    // Site memories: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            site_x_mem[count_reg[ADDR_W-1:0]] <= cand_reg.cand_x;
            site_y_mem[count_reg[ADDR_W-1:0]] <= cand_reg.cand_y;
        end
        if (issue)
        begin
            rdx_reg <= site_x_mem[rd_idx_reg[ADDR_W-1:0]];
            rdy_reg <= site_y_mem[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    // Distance pipeline: wrapped axis distances, then squares.
    always_ff @(posedge clk)
    begin
        dx_reg  <= axis_dist(cand_reg.cand_x, rdx_reg, box_width_reg);
        dy_reg  <= axis_dist(cand_reg.cand_y, rdy_reg, box_height_reg);
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
    end

    // Sum of squares against the minimum.
    assign d2        = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign too_close = v3_reg && (DIST_W'(d2) < min_dist_sq_reg);

    // Result register, free to accept a new item while a result waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_item_reg.status     <= status_reg;
            out_item_reg.site_index <= site_index_reg;
            out_item_reg.sites_held <= HELD_W'(count_reg);
            out_item_reg.done_res   <= is_full;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for periodic_min_distance_site_acceptor: directed table, then
// random phases with new box, spacing and target settings, all results checked in order.
// Depends on pmdsa_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb;
    import pmdsa_pkg::*;

    localparam int SITE_CAP    = 1024;
    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 47;

    // Rows of the directed table: a register write or a candidate item.
    typedef enum bit {ROW_REG, ROW_CAND} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [DIST_W-1:0]    reg_data;
        cand_item_t           cand;
        bit                   fixed;
        result_item_t         want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    cand_item_t           in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    result_item_t         out_item;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIST_W-1:0]    cfg_data = '0;

    // Mirror of the block's registers and site store.
    longint box_w = 65535;
    longint box_h = 65535;
    longint min_d2 = 0;
    longint target_cnt = 1024;
    logic [COORD_W-1:0] held_x [SITE_CAP];
    logic [COORD_W-1:0] held_y [SITE_CAP];
    int held_count = 0;

    result_item_t pending_results [$];
    stim_row_t    plan [$];
    int  mismatches = 0;
    int  send_gap_pct = 0;
    int  stall_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    periodic_min_distance_site_acceptor #(
        .MAX_SITES(SITE_CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Minimum-image distance along one axis; a stored coordinate may lie beyond the box.
    function automatic longint wrap_dist(input longint a, input longint b, input longint len);
        longint d;
        d = (a >= b) ? a - b : b - a;
        if (2 * d > len)
        begin
            d = (len >= d) ? len - d : d - len;
        end
        return d;
    endfunction

    // Decide what the block does with one candidate and update the site mirror.
    function automatic result_item_t judge_candidate(input cand_item_t c);
        result_item_t r;
        longint lim;
        longint dx;
        longint dy;
        bit clear;
        lim = (target_cnt > SITE_CAP) ? SITE_CAP : target_cnt;
        r.status = STAT_REJECT;
        r.site_index = '0;
        if (held_count >= lim)
        begin
            r.status = STAT_FULL;
        end
        else if (c.cand_x == 0 || c.cand_x >= box_w || c.cand_y == 0 || c.cand_y >= box_h)
        begin
            r.status = STAT_RANGE;
        end
        else
        begin
            clear = 1'b1;
            for (int j = 0; j < held_count; j++)
            begin
                dx = wrap_dist(c.cand_x, held_x[j], box_w);
                dy = wrap_dist(c.cand_y, held_y[j], box_h);
                if (dx * dx + dy * dy < min_d2)
                begin
                    clear = 1'b0;
                end
            end
            if (clear)
            begin
                held_x[held_count] = c.cand_x;
                held_y[held_count] = c.cand_y;
                r.site_index = IDX_W'(held_count);
                held_count++;
                r.status = STAT_ACCEPT;
            end
        end
        r.sites_held = HELD_W'(held_count);
        r.done_res = (held_count >= lim);
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [DIST_W-1:0] data);
        stim_row_t r;
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_data = data;
        r.cand = '0;
        r.fixed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic stim_row_t cand_row(input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y);
        stim_row_t r;
        r = reg_row(CFG_BOX_WIDTH, '0);
        r.kind = ROW_CAND;
        r.cand.cand_x = x;
        r.cand.cand_y = y;
        return r;
    endfunction

    // Candidate row whose result is written out by hand.
    function automatic stim_row_t cand_row_want(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input status_t st,
                                                input logic [IDX_W-1:0] idx,
                                                input logic [HELD_W-1:0] held,
                                                input logic done);
        stim_row_t r;
        r = cand_row(x, y);
        r.fixed = 1'b1;
        r.want.status = st;
        r.want.site_index = idx;
        r.want.sites_held = held;
        r.want.done_res = done;
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] random_box();
        case ($urandom_range(3))
            0: return 16'hFFFF;
            1: return COORD_W'($urandom_range(255, 2));
            default: return COORD_W'($urandom_range(65535, 256));
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= 100)
        begin
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        end
    endtask

    // Register write; the caller lowers the write enable with its next item.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_BOX_WIDTH:    box_w = data[COORD_W-1:0];
            CFG_BOX_HEIGHT:   box_h = data[COORD_W-1:0];
            CFG_MIN_DIST_SQ:  min_d2 = data;
            CFG_TARGET_COUNT: target_cnt = data[TGT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offer one candidate, with random idle gaps before it, until the block takes it.
    task automatic send_cand(input cand_item_t c, input bit fixed, input result_item_t want);
        result_item_t pred;
        cfg_we <= 1'b0;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= c;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pred = judge_candidate(c);
        pending_results.push_back(fixed ? want : pred);
    endtask

    // Let the block drain before touching its registers.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Result side: check each accepted result, then choose the next stall value.
    initial
    begin
        result_item_t exp_res;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    flag_mismatch("result with none pending, sites_held",
                                  out_item.sites_held, -1);
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (out_item.status != exp_res.status)
                        flag_mismatch("status", out_item.status, exp_res.status);
                    if (out_item.site_index != exp_res.site_index)
                        flag_mismatch("site_index", out_item.site_index, exp_res.site_index);
                    if (out_item.sites_held != exp_res.sites_held)
                        flag_mismatch("sites_held", out_item.sites_held, exp_res.sites_held);
                    if (out_item.done_res != exp_res.done_res)
                        flag_mismatch("done_res", out_item.done_res, exp_res.done_res);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TIMEOUT after %0d quiet cycles", quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Stimulus: reset, directed table, then random phases.
    initial
    begin
        cand_item_t c;
        int pick;
        int j;
        longint area;
        logic [TGT_W-1:0] tgt;

        // Range limits and extremes of spacing from reset.
        plan.push_back(cand_row_want(16'h0000, 16'h0000, STAT_RANGE, 0, 0, 1'b0));
        plan.push_back(cand_row_want(16'hFFFF, 16'h0080, STAT_RANGE, 0, 0, 1'b0));
        plan.push_back(cand_row_want(16'h0080, 16'hFFFF, STAT_RANGE, 0, 0, 1'b0));
        plan.push_back(cand_row_want(16'h0001, 16'h0001, STAT_ACCEPT, 0, 1, 1'b0));
        plan.push_back(cand_row_want(16'hFFFE, 16'hFFFE, STAT_ACCEPT, 1, 2, 1'b0));
        plan.push_back(reg_row(CFG_MIN_DIST_SQ, 34'h2_0000_0000));
        plan.push_back(cand_row_want(16'h8000, 16'h8000, STAT_REJECT, 0, 2, 1'b0));
        plan.push_back(reg_row(CFG_MIN_DIST_SQ, 34'd65536));
        plan.push_back(cand_row_want(16'h0002, 16'h0002, STAT_REJECT, 0, 2, 1'b0));
        // Close only across the wrap in x, then in y.
        plan.push_back(cand_row(16'hFFFD, 16'h0001));
        plan.push_back(cand_row(16'h0001, 16'hFFFD));
        plan.push_back(cand_row(16'h4000, 16'h4000));
        // Smallest box, with stored sites lying outside it.
        plan.push_back(reg_row(CFG_BOX_WIDTH, 34'd2));
        plan.push_back(reg_row(CFG_BOX_HEIGHT, 34'd2));
        plan.push_back(cand_row(16'h0001, 16'h0001));
        plan.push_back(cand_row_want(16'h0002, 16'h0001, STAT_RANGE, 0, 3, 1'b0));
        plan.push_back(reg_row(CFG_MIN_DIST_SQ, 34'd0));
        plan.push_back(cand_row(16'h0001, 16'h0001));
        // Target reached, full before range, and a zero target.
        plan.push_back(reg_row(CFG_BOX_WIDTH, 34'hFFFF));
        plan.push_back(reg_row(CFG_BOX_HEIGHT, 34'hFFFF));
        plan.push_back(reg_row(CFG_TARGET_COUNT, 34'd5));
        plan.push_back(cand_row_want(16'h0100, 16'h0100, STAT_ACCEPT, 4, 5, 1'b1));
        plan.push_back(cand_row_want(16'h0003, 16'h0003, STAT_FULL, 0, 5, 1'b1));
        plan.push_back(cand_row_want(16'h0000, 16'h0000, STAT_FULL, 0, 5, 1'b1));
        plan.push_back(reg_row(CFG_TARGET_COUNT, 34'd0));
        plan.push_back(cand_row_want(16'h0010, 16'h0010, STAT_FULL, 0, 5, 1'b1));
        plan.push_back(reg_row(CFG_TARGET_COUNT, 34'd2047));
        plan.push_back(cand_row(16'h0200, 16'h0300));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                if (!cfg_we)
                    settle_block();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end
            else
            begin
                send_cand(plan[i].cand, plan[i].fixed, plan[i].want);
            end
        end

        // Random phases: each picks a new box, spacing and target.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle_block();
            if (phase < 4)
            begin
                send_gap_pct = 9;
                stall_pct = 59;
            end
            else if (phase < 8)
            begin
                send_gap_pct = 59;
                stall_pct = 9;
            end
            else
            begin
                send_gap_pct = 0;
                stall_pct = 0;
            end
            write_reg(CFG_BOX_WIDTH, DIST_W'(random_box()));
            write_reg(CFG_BOX_HEIGHT, DIST_W'(random_box()));
            area = box_w * box_h;
            write_reg(CFG_MIN_DIST_SQ, DIST_W'(area / $urandom_range(300, 8)));
            if (phase == 5)
                tgt = 11'd2047;
            else if (phase == 9)
                tgt = 11'd1024;
            else
                tgt = TGT_W'(held_count + $urandom_range(40, 10));
            write_reg(CFG_TARGET_COUNT, DIST_W'(tgt));
            // Long receiver hold-off so the block backs up into its input.
            if (phase == 2 || phase == 6)
                hold_req = 1'b1;

            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                c.cand_x = COORD_W'($urandom_range(box_w - 1, 1));
                c.cand_y = COORD_W'($urandom_range(box_h - 1, 1));
                if (pick >= 70 && pick < 80 && held_count > 0)
                begin
                    // Near an existing site, possibly just past an edge.
                    j = $urandom_range(held_count - 1);
                    c.cand_x = held_x[j] + COORD_W'($urandom_range(6)) - 16'd3;
                    c.cand_y = held_y[j] + COORD_W'($urandom_range(6)) - 16'd3;
                end
                else if (pick >= 80 && pick < 90)
                begin
                    case ($urandom_range(3))
                        0: c.cand_x = '0;
                        1: c.cand_x = COORD_W'($urandom_range(65535, box_w));
                        2: c.cand_y = '0;
                        default: c.cand_y = COORD_W'($urandom_range(65535, box_h));
                    endcase
                end
                else if (pick >= 90)
                begin
                    c = cand_item_t'($urandom);
                end
                send_cand(c, 1'b0, '0);
            end
        end

        settle_block();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/pmdsa_pkg.sv
hw/rtl/periodic_min_distance_site_acceptor.sv
tb/sv/tb.sv
